>>> hdl/tced_pkg.sv
// ----------------------------------------------------------------------------
// tced_pkg
// Shared constants and types for the three-car dispatcher.
// ----------------------------------------------------------------------------
package tced_pkg;

  localparam int FLOOR_COUNT = 8;
  localparam int FW          = $clog2(FLOOR_COUNT);
  localparam logic [FW-1:0] TOP_FLOOR = FW'(FLOOR_COUNT - 1);

  localparam int CMD_W = 3;
  localparam logic [CMD_W-1:0] CMD_HALL_UP   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_HALL_DOWN = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CAR1      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SHARED    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_GROUND    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_TICK      = 3'd5;

  localparam logic [1:0] DIR_IDLE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  localparam int IN_W  = 8;
  localparam int OUT_W = 56;

  typedef struct packed {
    logic              load;
    logic              scan;
    logic [1:0]        car;
    logic [FW-1:0]     idx;
  } tced_cmd_t;

  typedef struct packed {
    logic car_done;
  } tced_stat_t;

endpackage

>>> hdl/tced_ctrl.sv
// ----------------------------------------------------------------------------
// tced_ctrl
// Sequencer: takes a transaction, walks the cars and floors on a tick,
// then presents the result.
// ----------------------------------------------------------------------------
module tced_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  input  logic [tced_pkg::CMD_W-1:0] in_command,
  output logic                    in_tready,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  input  tced_pkg::tced_stat_t    stat,
  output tced_pkg::tced_cmd_t     cmd
);
  import tced_pkg::*;

  typedef enum logic [2:0] {
    ST_WAIT = 3'b001,
    ST_SCAN = 3'b010,
    ST_SEND = 3'b100
  } state_t;

  state_t        state_r, state_nxt;
  logic [1:0]    car_r, car_nxt;
  logic [FW-1:0] idx_r, idx_nxt;

  assign in_tready  = (state_r == ST_WAIT);
  assign out_tvalid = (state_r == ST_SEND);

  always_comb begin
    cmd.load = in_tvalid && in_tready;
    cmd.scan = (state_r == ST_SCAN);
    cmd.car  = car_r;
    cmd.idx  = idx_r;
  end

  always_comb begin
    state_nxt = state_r;
    car_nxt   = car_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      ST_WAIT: begin
        if (in_tvalid) begin
          car_nxt = 2'd0;
          idx_nxt = '0;
          state_nxt = (in_command == CMD_TICK) ? ST_SCAN : ST_SEND;
        end
      end
      ST_SCAN: begin
        if (stat.car_done) begin
          idx_nxt = '0;
          if (car_r == 2'd2) begin
            state_nxt = ST_SEND;
          end else begin
            car_nxt = car_r + 2'd1;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_SEND: begin
        if (out_tready) state_nxt = ST_WAIT;
      end
      default: state_nxt = ST_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_WAIT;
      car_r   <= 2'd0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      car_r   <= car_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

>>> hdl/tced_dp.sv
// ----------------------------------------------------------------------------
// tced_dp
// Car and call state; evaluates one floor of one car per scan cycle.
// ----------------------------------------------------------------------------
module tced_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tced_pkg::tced_cmd_t           cmd,
  input  logic [tced_pkg::CMD_W-1:0]    in_command,
  input  logic [tced_pkg::FW-1:0]       in_floor,
  output tced_pkg::tced_stat_t          stat,
  output logic [tced_pkg::OUT_W-1:0]    result
);
  import tced_pkg::*;

  logic [FW-1:0]          pos_r [3];
  logic [2:0]             up_r, dn_r;
  logic [FLOOR_COUNT-1:0] hup_r, hdn_r;
  logic [FLOOR_COUNT-1:0] cab_r [3];

  logic [FW-1:0] p, f, r, np_up, np_dn;
  logic [1:0]    q;
  logic          mv_up, mv_dn, gu, gd, serves, hu, hd, cb;
  logic          ahead_up, ahead_dn, far_a, far_b, com_a, com_b, wa, wb;
  logic [FW:0]   sum, twof;

  always_comb begin
    p     = pos_r[cmd.car];
    mv_up = up_r[cmd.car];
    mv_dn = dn_r[cmd.car] && !mv_up;
    f     = mv_dn ? cmd.idx : TOP_FLOOR - cmd.idx;
    if (cmd.car == 2'd0) q = f[0] ? 2'd2 : 2'd1;
    else                 q = 2'd0;
    r  = pos_r[q];
    gu = up_r[q];
    gd = dn_r[q];
    case (cmd.car)
      2'd0:    serves = 1'b1;
      2'd1:    serves = !f[0];
      default: serves = f[0] || (f == '0);
    endcase
    hu = hup_r[f];
    hd = hdn_r[f];
    cb = cab_r[cmd.car][f];
    ahead_up = cb || (serves && (hu || hd) && (gd || r <= p || r > f));
    ahead_dn = cb || (serves && (hu || hd) && (gu || r >= p || r < f));
    sum  = {1'b0, r} + {1'b0, p};
    twof = {f, 1'b0};
    far_a = (cmd.car == 2'd0) ? (sum >= twof) : (sum > twof);
    far_b = (cmd.car == 2'd0) ? (sum <= twof) : (sum < twof);
    com_a = (r < p) || (r == p && !gu) || (r > f && far_a);
    com_b = (r > p) || (r == p && !gd) || (r < f && far_b);
    wa = (hu && ((gd && r < f) || com_a)) || (hd && ((gu && r > f) || com_a));
    wb = (hd && ((gu && r > f) || com_b)) || (hu && ((gd && r < f) || com_b));
    np_up = p + 1'b1;
    np_dn = p - 1'b1;
    if (mv_up)      stat.car_done = (f <= p) || ahead_up;
    else if (mv_dn) stat.car_done = (f >= p) || ahead_dn;
    else            stat.car_done = (cmd.idx == TOP_FLOOR) ||
                                    (f > p && (cb || (serves && wa))) ||
                                    (f < p && (cb || (serves && wb)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= '0;
        cab_r[i] <= '0;
      end
      up_r  <= '0;
      dn_r  <= '0;
      hup_r <= '0;
      hdn_r <= '0;
    end else if (cmd.load) begin
      case (in_command)
        CMD_HALL_UP:   if (in_floor != TOP_FLOOR) hup_r[in_floor] <= 1'b1;
        CMD_HALL_DOWN: if (in_floor != '0) hdn_r[in_floor] <= 1'b1;
        CMD_CAR1:      cab_r[0][in_floor] <= 1'b1;
        CMD_SHARED: begin
          if (in_floor[0]) cab_r[2][in_floor] <= 1'b1;
          else             cab_r[1][in_floor] <= 1'b1;
        end
        CMD_GROUND:    cab_r[2][0] <= 1'b1;
        default: ;
      endcase
    end else if (cmd.scan) begin
      if (mv_up) begin
        if (f <= p) begin
          up_r[cmd.car] <= 1'b0;
        end else if (ahead_up) begin
          pos_r[cmd.car] <= np_up;
          if (np_up == f) begin
            hup_r[f] <= 1'b0;
            hdn_r[f] <= 1'b0;
          end else begin
            hup_r[np_up] <= 1'b0;
          end
          cab_r[cmd.car][np_up] <= 1'b0;
        end
      end else if (mv_dn) begin
        if (f >= p) begin
          dn_r[cmd.car] <= 1'b0;
        end else if (ahead_dn) begin
          pos_r[cmd.car] <= np_dn;
          if (np_dn == f) begin
            hup_r[f] <= 1'b0;
            hdn_r[f] <= 1'b0;
          end else begin
            hdn_r[np_dn] <= 1'b0;
          end
          cab_r[cmd.car][np_dn] <= 1'b0;
        end
      end else begin
        if (f > p) begin
          if (cb || (serves && wa)) up_r[cmd.car] <= 1'b1;
        end else if (f < p) begin
          if (cb || (serves && wb)) dn_r[cmd.car] <= 1'b1;
        end else begin
          hup_r[f] <= 1'b0;
          hdn_r[f] <= 1'b0;
          cab_r[cmd.car][f] <= 1'b0;
        end
      end
    end
  end

  function automatic logic [1:0] dir_code(input logic u, input logic d);
    dir_code = u ? DIR_UP : (d ? DIR_DOWN : DIR_IDLE);
  endfunction

  assign result = {1'b0, cab_r[2], cab_r[1], cab_r[0], hdn_r, hup_r,
                   dir_code(up_r[2], dn_r[2]), dir_code(up_r[1], dn_r[1]),
                   dir_code(up_r[0], dn_r[0]), pos_r[2], pos_r[1], pos_r[0]};

endmodule

>>> hdl/three_car_elevator_dispatcher_unit.sv
// ----------------------------------------------------------------------------
// three_car_elevator_dispatcher_unit
// Three-car, eight-floor dispatcher with button latching and move ticks.
// ----------------------------------------------------------------------------
// Each input transaction yields one result transaction with the state after
// the update. A button event presents its result the cycle after it is
// accepted. A tick scans floors one per cycle for car one, two and three in
// turn, stopping early per car once a decision is made, then presents the
// result and returns to idle once it is taken.
// Input is accepted only while no result is outstanding.
module three_car_elevator_dispatcher_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [tced_pkg::IN_W-1:0]   in_tdata,  // command[2:0], floor[5:3]
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // car_one_floor[2:0], car_two_floor[5:3], car_three_floor[8:6],
  // car_one_direction[10:9], car_two_direction[12:11], car_three_direction[14:13],
  // pending_up_calls[22:15], pending_down_calls[30:23], car_one_requests[38:31],
  // car_two_requests[46:39], car_three_requests[54:47]
  output logic [tced_pkg::OUT_W-1:0]  out_tdata
);
  import tced_pkg::*;

  tced_cmd_t  cmd;
  tced_stat_t stat;

  tced_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_command (in_tdata[CMD_W-1:0]),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  tced_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_command (in_tdata[CMD_W-1:0]),
    .in_floor   (in_tdata[CMD_W+FW-1:CMD_W]),
    .stat       (stat),
    .result     (out_tdata)
  );

endmodule

>>> hdl/tced_checker.sv
// ----------------------------------------------------------------------------
// tced_checker
// Port-level checks for the dispatcher.
// ----------------------------------------------------------------------------
module tced_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic [tced_pkg::IN_W-1:0]  in_tdata,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [tced_pkg::OUT_W-1:0] out_tdata
);
  import tced_pkg::*;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("input taken while result pending");

  a_button_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tdata[CMD_W-1:0] != CMD_TICK) |=> out_tvalid)
    else $error("button result late");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result dropped or changed");

  a_hall_edges: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tdata[22] && !out_tdata[23]))
    else $error("hall call latched at an end floor");

  a_dir_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[10:9] != 2'd3 && out_tdata[12:11] != 2'd3 &&
                    out_tdata[14:13] != 2'd3))
    else $error("illegal direction code");

endmodule

bind three_car_elevator_dispatcher_unit tced_checker u_tced_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> tb/tb_three_car_elevator_dispatcher_checker.sv
// ----------------------------------------------------------------------------
// tb_three_car_elevator_dispatcher_checker
// Watches both channels, tracks the dispatcher state and compares every result.
// ----------------------------------------------------------------------------
module tb_three_car_elevator_dispatcher_checker
  import tced_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [IN_W-1:0]    in_tdata,
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic [OUT_W-1:0]   out_tdata,
  output int                 fail_count,
  output int                 pending_count
);

  typedef struct packed {
    logic [7:0] req3;
    logic [7:0] req2;
    logic [7:0] req1;
    logic [7:0] down_calls;
    logic [7:0] up_calls;
    logic [1:0] dir3;
    logic [1:0] dir2;
    logic [1:0] dir1;
    logic [2:0] pos3;
    logic [2:0] pos2;
    logic [2:0] pos1;
  } snapshot_t;

  int         pos [3];
  bit         up_flag [3];
  bit         dn_flag [3];
  logic [7:0] hall_up;
  logic [7:0] hall_dn;
  logic [7:0] cab [3];
  snapshot_t  expected_q [$];

  assign pending_count = expected_q.size();

  function automatic int partner(int c, int f);
    if (c == 0) return (f % 2) ? 2 : 1;
    return 0;
  endfunction

  function automatic bit serves(int c, int f);
    if (c == 0) return 1;
    if (c == 1) return (f % 2) == 0;
    return (f % 2) != 0 || f == 0;
  endfunction

  function automatic bit ahead(int c, int f, int p, bit up);
    int q, r;
    if (cab[c][f]) return 1;
    if (!serves(c, f) || !(hall_up[f] || hall_dn[f])) return 0;
    q = partner(c, f);
    r = pos[q];
    if (up) return dn_flag[q] || r <= p || r > f;
    return up_flag[q] || r >= p || r < f;
  endfunction

  function automatic void move_car(int c, bit up);
    int p, f, np;
    bit hit;
    p = pos[c];
    hit = 0;
    if (up) begin
      for (f = 7; f > p; f--) if (ahead(c, f, p, 1)) begin hit = 1; break; end
    end else begin
      for (f = 0; f < p; f++) if (ahead(c, f, p, 0)) begin hit = 1; break; end
    end
    if (!hit) begin
      if (up) up_flag[c] = 0; else dn_flag[c] = 0;
      return;
    end
    np = up ? p + 1 : p - 1;
    pos[c] = np;
    if (np == f) begin
      hall_up[f] = 0;
      hall_dn[f] = 0;
      cab[c][f] = 0;
    end else begin
      if (up) hall_up[np] = 0; else hall_dn[np] = 0;
      cab[c][np] = 0;
    end
  endfunction

  function automatic bit call_wanted(int c, int f, int p, bit above);
    int q, r;
    bit far_off, common;
    q = partner(c, f);
    r = pos[q];
    if (above) begin
      far_off = (c == 0) ? (r - f >= f - p) : (r - f > f - p);
      common = r < p || (r == p && !up_flag[q]) || (r > f && far_off);
      if (hall_up[f] && ((dn_flag[q] && r < f) || common)) return 1;
      if (hall_dn[f] && ((up_flag[q] && r > f) || common)) return 1;
    end else begin
      far_off = (c == 0) ? (p - f <= f - r) : (p - f < f - r);
      common = r > p || (r == p && !dn_flag[q]) || (r < f && far_off);
      if (hall_dn[f] && ((up_flag[q] && r > f) || common)) return 1;
      if (hall_up[f] && ((dn_flag[q] && r < f) || common)) return 1;
    end
    return 0;
  endfunction

  function automatic void pick_direction(int c);
    int p, f;
    p = pos[c];
    for (f = 7; f >= 0; f--) begin
      if (f > p) begin
        if (cab[c][f] || (serves(c, f) && call_wanted(c, f, p, 1))) begin
          up_flag[c] = 1;
          return;
        end
      end else if (f < p) begin
        if (cab[c][f] || (serves(c, f) && call_wanted(c, f, p, 0))) begin
          dn_flag[c] = 1;
          return;
        end
      end else begin
        hall_up[f] = 0;
        hall_dn[f] = 0;
        cab[c][f] = 0;
      end
    end
  endfunction

  function automatic logic [1:0] dir_of(int c);
    return up_flag[c] ? DIR_UP : (dn_flag[c] ? DIR_DOWN : DIR_IDLE);
  endfunction

  function automatic snapshot_t dispatch_event(logic [2:0] cmd, logic [2:0] fl);
    snapshot_t s;
    case (cmd)
      CMD_HALL_UP:   if (fl != TOP_FLOOR) hall_up[fl] = 1;
      CMD_HALL_DOWN: if (fl != 3'd0) hall_dn[fl] = 1;
      CMD_CAR1:      cab[0][fl] = 1;
      CMD_SHARED:    if (fl[0]) cab[2][fl] = 1; else cab[1][fl] = 1;
      CMD_GROUND:    cab[2][0] = 1;
      CMD_TICK: begin
        for (int c = 0; c < 3; c++) begin
          if (up_flag[c]) move_car(c, 1);
          else if (dn_flag[c]) move_car(c, 0);
          else pick_direction(c);
        end
      end
      default: ;
    endcase
    s.pos1 = 3'(pos[0]);  s.pos2 = 3'(pos[1]);  s.pos3 = 3'(pos[2]);
    s.dir1 = dir_of(0); s.dir2 = dir_of(1); s.dir3 = dir_of(2);
    s.up_calls = hall_up;
    s.down_calls = hall_dn;
    s.req1 = cab[0]; s.req2 = cab[1]; s.req3 = cab[2];
    return s;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fail_count++;
  endtask

  task automatic compare(snapshot_t g, snapshot_t w);
    if (g.pos1 != w.pos1) report("car_one_floor", g.pos1, w.pos1);
    if (g.pos2 != w.pos2) report("car_two_floor", g.pos2, w.pos2);
    if (g.pos3 != w.pos3) report("car_three_floor", g.pos3, w.pos3);
    if (g.dir1 != w.dir1) report("car_one_direction", g.dir1, w.dir1);
    if (g.dir2 != w.dir2) report("car_two_direction", g.dir2, w.dir2);
    if (g.dir3 != w.dir3) report("car_three_direction", g.dir3, w.dir3);
    if (g.up_calls != w.up_calls) report("pending_up_calls", g.up_calls, w.up_calls);
    if (g.down_calls != w.down_calls)
      report("pending_down_calls", g.down_calls, w.down_calls);
    if (g.req1 != w.req1) report("car_one_requests", g.req1, w.req1);
    if (g.req2 != w.req2) report("car_two_requests", g.req2, w.req2);
    if (g.req3 != w.req3) report("car_three_requests", g.req3, w.req3);
  endtask

  initial begin
    fail_count = 0;
    for (int c = 0; c < 3; c++) begin
      pos[c] = 0; up_flag[c] = 0; dn_flag[c] = 0; cab[c] = '0;
    end
    hall_up = '0;
    hall_dn = '0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          $display("unexpected result transaction");
          fail_count++;
        end else begin
          compare(snapshot_t'(out_tdata[54:0]), expected_q.pop_front());
        end
      end
      if (in_tvalid && in_tready)
        expected_q.push_back(dispatch_event(in_tdata[2:0], in_tdata[5:3]));
    end
  end

endmodule

>>> tb/tb_three_car_elevator_dispatcher_unit.sv
// ----------------------------------------------------------------------------
// tb_three_car_elevator_dispatcher_unit
// Drives button events and move ticks with random gaps and back-pressure.
// ----------------------------------------------------------------------------
module tb_three_car_elevator_dispatcher_unit;
  import tced_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_W-1:0]  out_tdata;
  int                fail_count;
  int                pending_count;
  bit                steady;

  three_car_elevator_dispatcher_unit dut (.*);

  tb_three_car_elevator_dispatcher_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Receiver stalls about a third of the time, except during the steady stretch.
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= steady || ($urandom_range(99) >= 33);
  end

  // Leave tvalid high after the accept; the next call replaces or drops it.
  task automatic send_event(logic [2:0] cmd, logic [2:0] fl);
    while (!steady && $urandom_range(99) < 33) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, fl, cmd};
    do @(posedge clk); while (!in_tready);
  endtask

  // Ticks interleaved with about as many calls so cars travel far; some odd commands.
  task automatic send_random;
    int k;
    logic [2:0] cmd;
    k = $urandom_range(99);
    if (k < 45) cmd = CMD_TICK;
    else if (k < 95) cmd = 3'($urandom_range(4));
    else cmd = 3'($urandom_range(7, 6));
    send_event(cmd, 3'($urandom));
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    steady = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_event(CMD_HALL_UP, 3'd7);
    send_event(CMD_HALL_DOWN, 3'd0);
    send_event(CMD_HALL_UP, 3'd0);
    send_event(CMD_HALL_DOWN, 3'd7);
    send_event(CMD_CAR1, 3'd7);
    send_event(CMD_SHARED, 3'd6);
    send_event(CMD_SHARED, 3'd5);
    send_event(CMD_GROUND, 3'd3);
    send_event(3'd6, 3'd2);
    send_event(3'd7, 3'd4);
    repeat (10) send_event(CMD_TICK, 3'd0);
    send_event(CMD_HALL_UP, 3'd3);
    send_event(CMD_HALL_DOWN, 3'd4);
    repeat (3) send_event(CMD_TICK, 3'd7);
    for (int i = 0; i < 1600; i++) begin
      if (i == 500) steady = 1'b1;
      if (i == 800) steady = 1'b0;
      if (i == 1000) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
      end
      send_random();
    end
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("[three_car_elevator_dispatcher_unit] OK");
    else $display("[three_car_elevator_dispatcher_unit] ERROR");
    $finish;
  end

  initial begin
    #8000000;
    $display("[three_car_elevator_dispatcher_unit] ERROR");
    $finish;
  end

endmodule

>>> files.f
hdl/tced_pkg.sv
hdl/tced_ctrl.sv
hdl/tced_dp.sv
hdl/three_car_elevator_dispatcher_unit.sv
hdl/tced_checker.sv
tb/tb_three_car_elevator_dispatcher_checker.sv
tb/tb_three_car_elevator_dispatcher_unit.sv
